// ===== design/lav_pkg.sv =====
// Shared constants for the look-at view matrix pipeline.
package lav_pkg;

  // Default word format: signed Q16.16
  localparam int WORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;

endpackage

// ===== design/look_at_view_matrix_top.sv =====
// Look-at view matrix: pipelined normalize, two cross products and three dot products.
//
//  channel | handshake            | payload
//  --------+----------------------+--------------------------------------------
//  in      | in_valid / in_stall  | eye_x..z, fwd_x..z, upv_x..z  (signed Q.F)
//  out     | out_valid / out_stall| r0_c0..r2_c3, rows 0..2 of the view matrix
//
// One camera set enters per cycle while in_stall is low; the depth is set by the
// square root (one stage per root bit) and the divider (one stage per quotient
// bit). Reset clears only the stage valid bits. A stall holds only the stages
// that carry an item; bubbles keep closing up, so input is taken while a finished
// result waits at the output register, as long as some stage is still empty.
module look_at_view_matrix_top #(
  parameter int WORD_BITS = lav_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = lav_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [WORD_BITS-1:0] eye_x,
  input  logic signed [WORD_BITS-1:0] eye_y,
  input  logic signed [WORD_BITS-1:0] eye_z,
  input  logic signed [WORD_BITS-1:0] fwd_x,
  input  logic signed [WORD_BITS-1:0] fwd_y,
  input  logic signed [WORD_BITS-1:0] fwd_z,
  input  logic signed [WORD_BITS-1:0] upv_x,
  input  logic signed [WORD_BITS-1:0] upv_y,
  input  logic signed [WORD_BITS-1:0] upv_z,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [WORD_BITS-1:0] r0_c0,
  output logic signed [WORD_BITS-1:0] r0_c1,
  output logic signed [WORD_BITS-1:0] r0_c2,
  output logic signed [WORD_BITS-1:0] r0_c3,
  output logic signed [WORD_BITS-1:0] r1_c0,
  output logic signed [WORD_BITS-1:0] r1_c1,
  output logic signed [WORD_BITS-1:0] r1_c2,
  output logic signed [WORD_BITS-1:0] r1_c3,
  output logic signed [WORD_BITS-1:0] r2_c0,
  output logic signed [WORD_BITS-1:0] r2_c1,
  output logic signed [WORD_BITS-1:0] r2_c2,
  output logic signed [WORD_BITS-1:0] r2_c3
);
  import lav_pkg::*;

  localparam int W  = WORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int Q  = F + 1;
  localparam int AW = 2 * W + 3;

  // stage map
  localparam int P_IN   = 0;
  localparam int P_SQ   = P_IN + 1;
  localparam int P_SUM  = P_SQ + 1;
  localparam int P_LEN  = P_SUM + W;
  localparam int P_Q    = P_LEN + Q;
  localparam int P_NUP  = P_Q + 1;
  localparam int P_X1M  = P_NUP + 1;
  localparam int P_LEFT = P_X1M + 1;
  localparam int P_X2M  = P_LEFT + 1;
  localparam int P_TUP  = P_X2M + 1;
  localparam int P_DM   = P_TUP + 1;
  localparam int P_OUT  = P_DM + 1;
  localparam int D      = P_OUT + 1;

  typedef logic signed [W-1:0]   word_t;
  typedef logic signed [2*W-1:0] prod_t;
  typedef logic signed [AW-1:0]  acc_t;

  typedef struct packed {
    logic [2:0][W-1:0] eye;
    logic [2:0][W-1:0] fwd;
    logic [2:0][W-1:0] nfw;
    logic [2:0][W-1:0] left;
    logic [2:0][W-1:0] tup;
    logic [2:0][W-1:0] mag;
    logic [2:0]        sgn;
    logic [W-1:0]      r0c3;
    logic [W-1:0]      r1c3;
    logic [W-1:0]      r2c3;
  } ctx_t;

  localparam acc_t ONE  = AW'(1);
  localparam acc_t SMAX = (ONE <<< (W - 1)) - ONE;
  localparam acc_t SMIN = -(ONE <<< (W - 1));
  localparam acc_t HALF = ONE <<< (F - 1);

  function automatic word_t sat_w(acc_t a);
    if (a > SMAX) return SMAX[W-1:0];
    if (a < SMIN) return SMIN[W-1:0];
    return a[W-1:0];
  endfunction

  function automatic word_t rnd(acc_t a);
    acc_t t;
    t = (a + HALF) >>> F;
    return sat_w(t);
  endfunction

  function automatic acc_t ext(prod_t p);
    return AW'(p);
  endfunction

  function automatic acc_t extw(logic [W-1:0] x);
    word_t s;
    s = x;
    return AW'(s);
  endfunction

  // stage valid bits and per-stage advance
  logic [D-1:0] vld;
  logic [D-1:0] en;

  assign en[D-1] = ~vld[D-1] | ~out_stall;
  for (genvar k = 0; k < D - 1; k++) begin : g_en
    assign en[k] = ~vld[k] | en[k+1];
  end

  assign in_stall  = ~en[0];
  assign out_valid = vld[D-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      for (int k = 1; k < D; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // side data that travels with every item
  ctx_t ctx_q [D];
  ctx_t ctx_d [D];

  logic [2*W-1:0] usq_q [3];
  prod_t          fe_q  [3];
  logic [2*W-1:0] sum_q;
  logic [W-1:0]   len;
  logic [Q-1:0]   quo   [3];
  word_t          nup_q [3];
  word_t          nup_d [3];
  prod_t          x1_q  [6];
  prod_t          x2_q  [6];
  prod_t          le_q  [3];
  prod_t          te_q  [3];

  logic  [2:0][W-1:0] in_eye;
  logic  [2:0][W-1:0] in_fwd;
  logic  [2:0][W-1:0] in_upv;
  assign in_eye = {eye_z, eye_y, eye_x};
  assign in_fwd = {fwd_z, fwd_y, fwd_x};
  assign in_upv = {upv_z, upv_y, upv_x};

  // build each stage's next side data
  always_comb begin
    ctx_d[0]     = '0;
    ctx_d[0].eye = in_eye;
    ctx_d[0].fwd = in_fwd;
    for (int i = 0; i < 3; i++) begin
      ctx_d[0].sgn[i] = in_upv[i][W-1];
      ctx_d[0].mag[i] = in_upv[i][W-1] ? (W'(0) - in_upv[i]) : in_upv[i];
    end
    for (int k = 1; k < D; k++) ctx_d[k] = ctx_q[k-1];

    ctx_d[P_SUM].r2c3 = rnd(ext(fe_q[0]) + ext(fe_q[1]) + ext(fe_q[2]));
    for (int i = 0; i < 3; i++) begin
      ctx_d[P_SUM].nfw[i] = sat_w(-extw(ctx_q[P_SUM-1].fwd[i]));
    end

    ctx_d[P_LEFT].left[0] = rnd(ext(x1_q[0]) - ext(x1_q[1]));
    ctx_d[P_LEFT].left[1] = rnd(ext(x1_q[2]) - ext(x1_q[3]));
    ctx_d[P_LEFT].left[2] = rnd(ext(x1_q[4]) - ext(x1_q[5]));

    ctx_d[P_TUP].tup[0] = rnd(ext(x2_q[0]) - ext(x2_q[1]));
    ctx_d[P_TUP].tup[1] = rnd(ext(x2_q[2]) - ext(x2_q[3]));
    ctx_d[P_TUP].tup[2] = rnd(ext(x2_q[4]) - ext(x2_q[5]));
    ctx_d[P_TUP].r0c3   = rnd(-(ext(le_q[0]) + ext(le_q[1]) + ext(le_q[2])));

    ctx_d[P_OUT].r1c3 = rnd(-(ext(te_q[0]) + ext(te_q[1]) + ext(te_q[2])));
  end

  for (genvar k = 0; k < D; k++) begin : g_ctx
    always_ff @(posedge clk) begin
      if (en[k]) ctx_q[k] <= ctx_d[k];
    end
  end

  // squares of the up magnitudes and forward-eye products
  always_ff @(posedge clk) begin
    if (en[P_SQ]) begin
      for (int i = 0; i < 3; i++) begin
        usq_q[i] <= ctx_q[P_IN].mag[i] * ctx_q[P_IN].mag[i];
        fe_q[i]  <= $signed(ctx_q[P_IN].fwd[i]) * $signed(ctx_q[P_IN].eye[i]);
      end
    end
  end

  // sum of squares
  always_ff @(posedge clk) begin
    if (en[P_SUM]) sum_q <= usq_q[0] + usq_q[1] + usq_q[2];
  end

  lav_sqrt #(.W(W)) u_sqrt (
    .clk  (clk),
    .en   (en[P_LEN:P_SUM+1]),
    .sum  (sum_q),
    .root (len)
  );

  for (genvar i = 0; i < 3; i++) begin : g_div
    lav_div #(.W(W), .F(F)) u_div (
      .clk (clk),
      .en  (en[P_Q:P_LEN+1]),
      .m   (ctx_q[P_LEN].mag[i]),
      .len (len),
      .q   (quo[i])
    );
  end

  // apply sign, saturate, force zero for a zero-length up
  always_comb begin
    acc_t qa;
    for (int i = 0; i < 3; i++) begin
      qa = AW'(quo[i]);
      if (ctx_q[P_Q].sgn[i]) qa = -qa;
      if (ctx_q[P_Q].mag == '0) nup_d[i] = '0;
      else nup_d[i] = sat_w(qa);
    end
  end

  always_ff @(posedge clk) begin
    if (en[P_NUP]) begin
      for (int i = 0; i < 3; i++) nup_q[i] <= nup_d[i];
    end
  end

  // left = forward x normalized up, products
  always_ff @(posedge clk) begin
    if (en[P_X1M]) begin
      x1_q[0] <= $signed(ctx_q[P_NUP].fwd[1]) * nup_q[2];
      x1_q[1] <= $signed(ctx_q[P_NUP].fwd[2]) * nup_q[1];
      x1_q[2] <= $signed(ctx_q[P_NUP].fwd[2]) * nup_q[0];
      x1_q[3] <= $signed(ctx_q[P_NUP].fwd[0]) * nup_q[2];
      x1_q[4] <= $signed(ctx_q[P_NUP].fwd[0]) * nup_q[1];
      x1_q[5] <= $signed(ctx_q[P_NUP].fwd[1]) * nup_q[0];
    end
  end

  // true up = left x forward, and left . eye, products
  always_ff @(posedge clk) begin
    if (en[P_X2M]) begin
      x2_q[0] <= $signed(ctx_q[P_LEFT].left[1]) * $signed(ctx_q[P_LEFT].fwd[2]);
      x2_q[1] <= $signed(ctx_q[P_LEFT].left[2]) * $signed(ctx_q[P_LEFT].fwd[1]);
      x2_q[2] <= $signed(ctx_q[P_LEFT].left[2]) * $signed(ctx_q[P_LEFT].fwd[0]);
      x2_q[3] <= $signed(ctx_q[P_LEFT].left[0]) * $signed(ctx_q[P_LEFT].fwd[2]);
      x2_q[4] <= $signed(ctx_q[P_LEFT].left[0]) * $signed(ctx_q[P_LEFT].fwd[1]);
      x2_q[5] <= $signed(ctx_q[P_LEFT].left[1]) * $signed(ctx_q[P_LEFT].fwd[0]);
      for (int i = 0; i < 3; i++) begin
        le_q[i] <= $signed(ctx_q[P_LEFT].left[i]) * $signed(ctx_q[P_LEFT].eye[i]);
      end
    end
  end

  // true up . eye, products
  always_ff @(posedge clk) begin
    if (en[P_DM]) begin
      for (int i = 0; i < 3; i++) begin
        te_q[i] <= $signed(ctx_q[P_TUP].tup[i]) * $signed(ctx_q[P_TUP].eye[i]);
      end
    end
  end

  // drive the result transfer from the last stage
  assign r0_c0 = ctx_q[P_OUT].left[0];
  assign r0_c1 = ctx_q[P_OUT].left[1];
  assign r0_c2 = ctx_q[P_OUT].left[2];
  assign r0_c3 = ctx_q[P_OUT].r0c3;
  assign r1_c0 = ctx_q[P_OUT].tup[0];
  assign r1_c1 = ctx_q[P_OUT].tup[1];
  assign r1_c2 = ctx_q[P_OUT].tup[2];
  assign r1_c3 = ctx_q[P_OUT].r1c3;
  assign r2_c0 = ctx_q[P_OUT].nfw[0];
  assign r2_c1 = ctx_q[P_OUT].nfw[1];
  assign r2_c2 = ctx_q[P_OUT].nfw[2];
  assign r2_c3 = ctx_q[P_OUT].r2c3;

endmodule

// ===== design/lav_sqrt.sv =====
// Pipelined integer square root, one root bit resolved per stage.
module lav_sqrt #(
  parameter int W = lav_pkg::WORD_BITS_DEF
) (
  input  logic             clk,
  input  logic [W-1:0]     en,
  input  logic [2*W-1:0]   sum,
  output logic [W-1:0]     root
);
  import lav_pkg::*;

  localparam int RW = W + 3;

  logic [RW-1:0]  rem_q [W];
  logic [W-1:0]   rt_q  [W];
  logic [2*W-1:0] s_q   [W];

  for (genvar i = 0; i < W; i++) begin : g_step
    logic [RW-1:0]  rem_in;
    logic [W-1:0]   rt_in;
    logic [2*W-1:0] s_in;
    logic [RW-1:0]  r2;
    logic [RW-1:0]  trial;

    if (i == 0) begin : g_first
      assign rem_in = '0;
      assign rt_in  = '0;
      assign s_in   = sum;
    end else begin : g_next
      assign rem_in = rem_q[i-1];
      assign rt_in  = rt_q[i-1];
      assign s_in   = s_q[i-1];
    end

    // bring down the next two radicand bits and form the trial subtrahend
    always_comb begin
      r2    = {rem_in[RW-3:0], s_in[2*W-1 -: 2]};
      trial = RW'({rt_in, 2'b01});
    end

    // advance one root bit
    always_ff @(posedge clk) begin
      if (en[i]) begin
        s_q[i] <= s_in << 2;
        if (r2 >= trial) begin
          rem_q[i] <= r2 - trial;
          rt_q[i]  <= {rt_in[W-2:0], 1'b1};
        end else begin
          rem_q[i] <= r2;
          rt_q[i]  <= {rt_in[W-2:0], 1'b0};
        end
      end
    end
  end

  assign root = rt_q[W-1];

endmodule

// ===== design/lav_div.sv =====
// Pipelined restoring divider for one normalized component, one quotient bit per stage.
module lav_div #(
  parameter int W = lav_pkg::WORD_BITS_DEF,
  parameter int F = lav_pkg::FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic [F:0]   en,
  input  logic [W-1:0] m,
  input  logic [W-1:0] len,
  output logic [F:0]   q
);
  import lav_pkg::*;

  localparam int Q  = F + 1;
  localparam int NB = W + F + 1;

  logic [W-1:0] rem_q [Q];
  logic [Q-1:0] lo_q  [Q];
  logic [Q-1:0] q_q   [Q];
  logic [W-1:0] len_q [Q];

  // rounded numerator: m * 2^F + len/2; its top part is already below len
  logic [NB-1:0] num;
  assign num = NB'({m, {F{1'b0}}}) + NB'(len >> 1);

  for (genvar i = 0; i < Q; i++) begin : g_step
    logic [W-1:0] rem_in;
    logic [Q-1:0] lo_in;
    logic [Q-1:0] q_in;
    logic [W-1:0] len_in;
    logic [W:0]   r2;
    logic [W:0]   lenx;

    if (i == 0) begin : g_first
      assign rem_in = num[NB-1:Q];
      assign lo_in  = num[Q-1:0];
      assign q_in   = '0;
      assign len_in = len;
    end else begin : g_next
      assign rem_in = rem_q[i-1];
      assign lo_in  = lo_q[i-1];
      assign q_in   = q_q[i-1];
      assign len_in = len_q[i-1];
    end

    always_comb begin
      r2   = {rem_in, lo_in[Q-1]};
      lenx = {1'b0, len_in};
    end

    // shift in one numerator bit, subtract when it fits
    always_ff @(posedge clk) begin
      if (en[i]) begin
        lo_q[i]  <= lo_in << 1;
        len_q[i] <= len_in;
        if (r2 >= lenx) begin
          rem_q[i] <= W'(r2 - lenx);
          q_q[i]   <= {q_in[Q-2:0], 1'b1};
        end else begin
          rem_q[i] <= W'(r2);
          q_q[i]   <= {q_in[Q-2:0], 1'b0};
        end
      end
    end
  end

  assign q = q_q[Q-1];

endmodule
